[rtl/core/pcrp_pkg.sv]
`default_nettype none
package pcrp_pkg;

  localparam int COEF_W   = 64;
  localparam int LIMB_W   = 64;
  localparam int ACC_W    = 2 * LIMB_W;
  localparam int FRAC_W   = 40;
  localparam int ROW_W    = 10;
  localparam int DIM_W    = 11;
  localparam int DEG_W    = 2;
  localparam int CNT_W    = 4;
  localparam int CURVE_W  = 3;
  localparam int TERM_F_W = 2;
  localparam int X_W      = 16;
  localparam int PIX_W    = 20;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_WIDTH       = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEGREE      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CURVE_COUNT = 2'd3;

  typedef logic [COEF_W-1:0]       coef_t;
  typedef logic [ACC_W-1:0]        acc_t;
  typedef logic signed [X_W-1:0]   xpos_t;

endpackage
`default_nettype wire

[rtl/core/pcrp_coef_ram.sv]
`default_nettype none
module pcrp_coef_ram #(
  parameter int DEPTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire pcrp_pkg::coef_t     wr_data,
  input  wire logic [ADDR_W-1:0]   rd_addr,
  output pcrp_pkg::coef_t          rd_data
);
  import pcrp_pkg::*;

  coef_t mem [DEPTH];
  coef_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[rtl/core/pcrp_round_sat.sv]
`default_nettype none
module pcrp_round_sat (
  input  wire pcrp_pkg::acc_t   mag,
  input  wire logic             neg,
  output pcrp_pkg::xpos_t       x
);
  import pcrp_pkg::*;

  localparam int QB = FRAC_W + X_W - 1;

  acc_t  rnd;
  logic  over_hi;
  logic  q_top;
  logic [X_W-2:0] q_low;

  always_comb begin
    rnd     = mag + (ACC_W'(1) << (FRAC_W - 1));
    over_hi = |rnd[ACC_W-1:QB+1];
    q_top   = rnd[QB];
    q_low   = rnd[QB-1:FRAC_W];
    if (!neg) begin
      if (over_hi || q_top) begin
        x = {1'b0, {(X_W-1){1'b1}}};
      end else begin
        x = {1'b0, q_low};
      end
    end else begin
      if (over_hi || (q_top && (|q_low))) begin
        x = {1'b1, {(X_W-1){1'b0}}};
      end else begin
        x = X_W'(0) - {q_top, q_low};
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/polynomial_curve_row_plotter_core.sv]
// load transfer: written into the coefficient memory in the accept cycle if curve and term are in range, busy stays low
// render transfer: busy while the N active curves are evaluated, for an in-range row and a nonzero curve count
// each curve runs its horner terms, then the abs, round and output states, before its strobe
// the horner terms use the shared 64x10 multiply-accumulate unit, two limb passes per horner term
// results are strobed once and cannot be stalled by the receiver
// reset idles control and loads config register defaults; coefficient memory undefined until loaded
`default_nettype none
module polynomial_curve_row_plotter_core #(
  parameter int MAX_CURVES = 8,
  parameter int MAX_DEGREE = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_kind,
  input  wire logic [pcrp_pkg::CURVE_W-1:0]      in_curve,
  input  wire logic [pcrp_pkg::TERM_F_W-1:0]     in_term,
  input  wire logic signed [pcrp_pkg::COEF_W-1:0] in_coeff_value,
  input  wire logic [pcrp_pkg::ROW_W-1:0]        in_row,
  input  wire logic                              cfg_we,
  input  wire logic [pcrp_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [pcrp_pkg::DIM_W-1:0]        cfg_data,
  output logic                                   out_valid,
  output logic [pcrp_pkg::CURVE_W-1:0]           out_curve_index,
  output logic signed [pcrp_pkg::X_W-1:0]        out_x_position,
  output logic [pcrp_pkg::PIX_W-1:0]             out_pixel_index,
  output logic                                   out_in_range,
  output logic                                   out_last
);
  import pcrp_pkg::*;

  localparam int TERMS  = MAX_DEGREE + 1;
  localparam int DEPTH  = MAX_CURVES * TERMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TERM_W = $clog2(TERMS);
  localparam int DIM_MAX = (1 << DIM_W) - 1;
  localparam int W_LIM  = (MAX_WIDTH  > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
  localparam int H_LIM  = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
  localparam int C_LIM  = (MAX_CURVES > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : MAX_CURVES;
  localparam int PROD_W = LIMB_W + ROW_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CARRY_W = SUM_W - LIMB_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LO   = 3'd1;
  localparam logic [2:0] S_HI   = 3'd2;
  localparam logic [2:0] S_ABS  = 3'd3;
  localparam logic [2:0] S_RND  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [DIM_W-1:0] width_r, height_r;
  logic [DEG_W-1:0] degree_r;
  logic [CNT_W-1:0] curve_count_r;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [TERM_W-1:0] i_r, i_nxt;
  logic [ROW_W-1:0]  y_r, y_nxt;
  logic [PIX_W-1:0]  yw_r, yw_nxt;
  logic [LIMB_W-1:0] acc_lo_r, acc_lo_nxt, acc_hi_r, acc_hi_nxt;
  logic [CARRY_W-1:0] carry_r, carry_nxt;
  acc_t              mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  xpos_t             x_r, x_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CURVE_W-1:0] out_curve_index_r, out_curve_index_nxt;
  xpos_t             out_x_position_r, out_x_position_nxt;
  logic [PIX_W-1:0]  out_pixel_index_r, out_pixel_index_nxt;
  logic              out_in_range_r, out_in_range_nxt;
  logic              out_last_r, out_last_nxt;

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [TERM_W-1:0] deg_eff;
  logic [CNT_W-1:0]  cnt_eff;
  logic              load_ok;
  logic              row_ok;
  logic [ROW_W+DIM_W-1:0] yw_full;

  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  coef_t             rd_data;

  logic [LIMB_W-1:0] mul_a, add_b;
  logic [CARRY_W-1:0] add_c;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  mac_sum;
  acc_t              acc_full;
  xpos_t             x_rnd;
  logic              x_ok;

  assign w_eff   = (width_r  > DIM_W'(W_LIM)) ? DIM_W'(W_LIM) : width_r;
  assign h_eff   = (height_r > DIM_W'(H_LIM)) ? DIM_W'(H_LIM) : height_r;
  assign deg_eff = (int'(degree_r) > MAX_DEGREE) ? TERM_W'(MAX_DEGREE) : TERM_W'(degree_r);
  assign cnt_eff = (curve_count_r > CNT_W'(C_LIM)) ? CNT_W'(C_LIM) : curve_count_r;

  assign load_ok = (int'(in_curve) < MAX_CURVES) && (int'(in_term) <= MAX_DEGREE);
  assign row_ok  = {1'b0, in_row} < h_eff;
  assign yw_full = in_row * w_eff;
  assign wr_addr = ADDR_W'(int'(in_curve) * TERMS + int'(in_term));
  assign rd_addr = ADDR_W'(int'(k_nxt) * TERMS + int'(i_nxt));

  // shared limb multiply-accumulate, low limb then high limb with carry
  assign mul_a   = (state_r == S_HI) ? acc_hi_r : acc_lo_r;
  assign add_b   = (state_r == S_HI) ? {LIMB_W{rd_data[COEF_W-1]}} : LIMB_W'(rd_data);
  assign add_c   = (state_r == S_HI) ? carry_r : '0;
  assign prod    = mul_a * y_r;
  assign mac_sum = SUM_W'(prod) + SUM_W'(add_b) + SUM_W'(add_c);

  assign acc_full = {acc_hi_r, acc_lo_r};
  assign x_ok     = !x_r[X_W-1] && (x_r[X_W-2:0] < (X_W-1)'(w_eff));

  pcrp_coef_ram #(
    .DEPTH (DEPTH)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_addr),
    .wr_data (coef_t'(in_coeff_value)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pcrp_round_sat u_round_sat (
    .mag (mag_r),
    .neg (neg_r),
    .x   (x_rnd)
  );

  always_comb begin
    state_nxt           = state_r;
    k_nxt               = k_r;
    i_nxt               = i_r;
    y_nxt               = y_r;
    yw_nxt              = yw_r;
    acc_lo_nxt          = acc_lo_r;
    acc_hi_nxt          = acc_hi_r;
    carry_nxt           = carry_r;
    mag_nxt             = mag_r;
    neg_nxt             = neg_r;
    x_nxt               = x_r;
    out_valid_nxt       = 1'b0;
    out_curve_index_nxt = out_curve_index_r;
    out_x_position_nxt  = out_x_position_r;
    out_pixel_index_nxt = out_pixel_index_r;
    out_in_range_nxt    = out_in_range_r;
    out_last_nxt        = out_last_r;
    mem_we              = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!in_kind) begin
            mem_we = load_ok;
          end else if (row_ok && (cnt_eff != '0)) begin
            state_nxt  = S_LO;
            k_nxt      = '0;
            i_nxt      = '0;
            acc_lo_nxt = '0;
            acc_hi_nxt = '0;
            y_nxt      = in_row;
            yw_nxt     = PIX_W'(yw_full);
          end
        end
      end
      S_LO: begin
        acc_lo_nxt = mac_sum[LIMB_W-1:0];
        carry_nxt  = mac_sum[SUM_W-1:LIMB_W];
        state_nxt  = S_HI;
      end
      S_HI: begin
        acc_hi_nxt = mac_sum[LIMB_W-1:0];
        if (i_r == deg_eff) begin
          state_nxt = S_ABS;
        end else begin
          i_nxt     = i_r + TERM_W'(1);
          state_nxt = S_LO;
        end
      end
      S_ABS: begin
        neg_nxt   = acc_hi_r[LIMB_W-1];
        mag_nxt   = acc_hi_r[LIMB_W-1] ? (ACC_W'(0) - acc_full) : acc_full;
        state_nxt = S_RND;
      end
      S_RND: begin
        x_nxt     = x_rnd;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt       = 1'b1;
        out_curve_index_nxt = k_r[CURVE_W-1:0];
        out_x_position_nxt  = x_r;
        out_in_range_nxt    = x_ok;
        out_pixel_index_nxt = x_ok ? (yw_r + PIX_W'(x_r[X_W-2:0])) : '0;
        out_last_nxt        = (k_r == cnt_eff - CNT_W'(1));
        acc_lo_nxt          = '0;
        acc_hi_nxt          = '0;
        i_nxt               = '0;
        if (k_r == cnt_eff - CNT_W'(1)) begin
          k_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_LO;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      k_r           <= '0;
      i_r           <= '0;
      out_valid_r   <= 1'b0;
      width_r       <= DIM_W'(512);
      height_r      <= DIM_W'(512);
      degree_r      <= DEG_W'(3);
      curve_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:       width_r       <= cfg_data;
          REG_HEIGHT:      height_r      <= cfg_data;
          REG_DEGREE:      degree_r      <= cfg_data[DEG_W-1:0];
          REG_CURVE_COUNT: curve_count_r <= cfg_data[CNT_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    y_r               <= y_nxt;
    yw_r              <= yw_nxt;
    acc_lo_r          <= acc_lo_nxt;
    acc_hi_r          <= acc_hi_nxt;
    carry_r           <= carry_nxt;
    mag_r             <= mag_nxt;
    neg_r             <= neg_nxt;
    x_r               <= x_nxt;
    out_curve_index_r <= out_curve_index_nxt;
    out_x_position_r  <= out_x_position_nxt;
    out_pixel_index_r <= out_pixel_index_nxt;
    out_in_range_r    <= out_in_range_nxt;
    out_last_r        <= out_last_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_curve_index = out_curve_index_r;
  assign out_x_position  = out_x_position_r;
  assign out_pixel_index = out_pixel_index_r;
  assign out_in_range    = out_in_range_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire
